FILE: sv/cms_pkg.sv
`default_nettype none

package cms_pkg;

  localparam int unsigned PayloadLen = 7;
  localparam int unsigned FrameLen   = 8;
  localparam int unsigned IdxW       = $clog2(PayloadLen);
  localparam int unsigned CntW       = $clog2(PayloadLen + 1);
  localparam int unsigned BeatW      = $clog2(FrameLen);

  localparam logic [7:0] HdrSingle = 8'hC8;
  localparam logic [7:0] HdrFirst  = 8'h8F;
  localparam logic [7:0] HdrMiddle = 8'h08;
  localparam logic [7:0] HdrLast   = 8'h48;

  localparam logic [CntW-1:0]  CountFull = CntW'(PayloadLen);
  localparam logic [BeatW-1:0] BeatLast  = BeatW'(FrameLen - 1);

  // Program steps of the sequencer.
  typedef enum logic [1:0] {
    S_IDLE,
    S_FULL,
    S_HOLD,
    S_END
  } step_t;

  // Jump conditions evaluated at the end of a step.
  typedef enum logic [1:0] {
    J_INPUT,
    J_FRAME,
    J_FIN
  } jump_t;

  typedef struct packed {
    logic  take_in;
    logic  emit;
    logic  last_frame;
    logic  store_hold;
    jump_t cond;
    step_t nxt_a;
    step_t nxt_b;
  } ctl_t;

  typedef struct packed {
    logic full;
    logic fin;
    logic frame_done;
  } stat_t;

  // Microcode store: one control word for each program step.
  function automatic ctl_t ucode(input step_t s);
    ctl_t c;
    c = '{take_in: 1'b0, emit: 1'b0, last_frame: 1'b0, store_hold: 1'b0,
          cond: J_INPUT, nxt_a: S_IDLE, nxt_b: S_IDLE};
    case (s)
      S_IDLE: begin
        c.take_in = 1'b1;
        c.cond    = J_INPUT;
        c.nxt_a   = S_FULL;
        c.nxt_b   = S_END;
      end
      S_FULL: begin
        c.emit  = 1'b1;
        c.cond  = J_FRAME;
        c.nxt_a = S_HOLD;
      end
      S_HOLD: begin
        c.store_hold = 1'b1;
        c.cond       = J_FIN;
        c.nxt_a      = S_IDLE;
        c.nxt_b      = S_END;
      end
      S_END: begin
        c.emit       = 1'b1;
        c.last_frame = 1'b1;
        c.cond       = J_FRAME;
        c.nxt_a      = S_IDLE;
      end
      default: begin
        c.cond = J_INPUT;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: sv/cms_seq.sv
`default_nettype none

module cms_seq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic          in_tlast,
  input  wire cms_pkg::stat_t stat,
  output cms_pkg::ctl_t      ctl
);
  import cms_pkg::*;

  step_t step_r;
  step_t step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_comb begin
    ctl = ucode(step_r);
  end

  always_comb begin
    step_nxt = step_r;
    case (ctl.cond)
      J_INPUT: begin
        if (in_tvalid) begin
          if (stat.full) begin
            step_nxt = ctl.nxt_a;
          end else if (in_tlast) begin
            step_nxt = ctl.nxt_b;
          end
        end
      end
      J_FRAME: begin
        if (stat.frame_done) begin
          step_nxt = ctl.nxt_a;
        end
      end
      J_FIN: begin
        step_nxt = stat.fin ? ctl.nxt_b : ctl.nxt_a;
      end
      default: begin
        step_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/cms_datapath.sv
`default_nettype none

module cms_datapath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cms_pkg::ctl_t ctl,
  output cms_pkg::stat_t     stat,
  input  wire logic          in_tvalid,
  input  wire logic [7:0]    in_tdata,
  input  wire logic          in_tlast,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast,
  output logic [1:0]         out_tuser
);
  import cms_pkg::*;

  logic [7:0]       pend_r [PayloadLen];
  logic [7:0]       hold_r;
  logic             fin_r;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             sent_r, sent_nxt;
  logic [2:0]       seq_r, seq_nxt;
  logic [BeatW-1:0] beat_r, beat_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r;
  logic             out_fend_r, out_mend_r, out_rend_r;

  logic             accept;
  logic             store_in;
  logic             emit_go;
  logic             frame_done;
  logic [IdxW-1:0]  pidx;
  logic [7:0]       hdr_full, hdr_end, beat_byte;

  assign accept     = in_tvalid && ctl.take_in;
  assign store_in   = accept && (count_r != CountFull);
  assign emit_go    = ctl.emit && (!out_valid_r || out_tready);
  assign frame_done = emit_go && (beat_r == BeatLast);

  assign stat = '{full: (count_r == CountFull), fin: fin_r, frame_done: frame_done};

  // Payload position of the current beat; the header beat never reads it.
  assign pidx = IdxW'(beat_r - BeatW'(1));

  assign hdr_full = sent_r ? (HdrMiddle + {5'd0, seq_r}) : HdrFirst;
  assign hdr_end  = (sent_r ? HdrLast : HdrSingle) + 8'(count_r);

  always_comb begin
    if (beat_r == '0) begin
      beat_byte = ctl.last_frame ? hdr_end : hdr_full;
    end else if (CntW'(pidx) < count_r) begin
      beat_byte = pend_r[pidx];
    end else begin
      beat_byte = 8'd0;
    end
  end

  always_comb begin
    count_nxt = count_r;
    sent_nxt  = sent_r;
    seq_nxt   = seq_r;
    beat_nxt  = emit_go ? beat_r + BeatW'(1) : beat_r;
    if (store_in) begin
      count_nxt = count_r + CntW'(1);
    end
    if (ctl.store_hold) begin
      count_nxt = CntW'(1);
    end
    if (frame_done) begin
      if (ctl.last_frame) begin
        count_nxt = '0;
        sent_nxt  = 1'b0;
        seq_nxt   = '0;
      end else begin
        sent_nxt = 1'b1;
        if (sent_r) begin
          seq_nxt = seq_r + 3'd1;
        end
      end
    end
  end

  always_comb begin
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      sent_r      <= 1'b0;
      seq_r       <= '0;
      beat_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      sent_r      <= sent_nxt;
      seq_r       <= seq_nxt;
      beat_r      <= beat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_in) begin
      pend_r[IdxW'(count_r)] <= in_tdata;
    end else if (ctl.store_hold) begin
      pend_r[0] <= hold_r;
    end
    if (accept) begin
      hold_r <= in_tdata;
      fin_r  <= in_tlast;
    end
    if (emit_go) begin
      out_byte_r <= beat_byte;
      out_fend_r <= (beat_r == BeatLast);
      out_mend_r <= (beat_r == BeatLast) && ctl.last_frame;
      // A full frame ends the word's results unless a last frame follows.
      out_rend_r <= (beat_r == BeatLast) && (ctl.last_frame || !fin_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_fend_r;
  assign out_tuser  = {out_rend_r, out_mend_r};

`ifndef SYNTHESIS
  a_run_end_on_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rend_r |-> out_fend_r)
    else $error("run end flagged away from a frame end");

  a_full_frame_has_seven: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit && !ctl.last_frame |-> count_r == CountFull)
    else $error("full frame started without seven held bytes");

  a_message_clears: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done && ctl.last_frame |=> count_r == '0 && !sent_r && seq_r == '0)
    else $error("message state not cleared after its last frame");
`endif

endmodule

`default_nettype wire

FILE: sv/can_message_segmenter.sv
// Non-final word while fewer than seven bytes are held: taken and held, no output.
// Word arriving with seven bytes held: the full frame is sent, then the word is stored.
// Final word: one eight-beat frame (sixteen if seven held), one beat per cycle unless stalled.
// Each beat is registered in the output register, which holds it while out_tready is low.
// Reset (rst_n low, synchronous) empties the hold and clears the sequence state.
`default_nettype none

module can_message_segmenter (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // data_byte
  input  wire logic       in_tlast,   // final_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // frame_byte
  output logic            out_tlast,  // frame_end
  output logic [1:0]      out_tuser   // run_end, message_end
);
  import cms_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  cms_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .stat      (stat),
    .ctl       (ctl)
  );

  cms_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .stat       (stat),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  assign in_tready = ctl.take_in;

endmodule

`default_nettype wire
